// File: hw/rtl/nprs_pkg.sv
// Package for the Newton polynomial root solver: widths, codes and shared types.
// Used by nprs_divider and newton_polynomial_root_solver; depends on nothing.
package nprs_pkg;

    localparam int MAX_DEGREE_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_W         = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int ITER_W         = 10;
    localparam int DEG_W          = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEGREE   = 2'd0,
        REG_REL_TOL  = 2'd1,
        REG_MAX_ITER = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_CONVERGED = 2'd0,
        ST_ITER_CAP  = 2'd1,
        ST_ZERO_DER  = 2'd2,
        ST_SATURATED = 2'd3
    } solve_status_t;

    // Saturate a 64-bit signed value to 32 bits; flag when clipping happened.
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sd2147483647)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -64'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage

// File: hw/rtl/nprs_divider.sv
// Restoring signed divider, one quotient bit per cycle, truncation toward zero.
// Depends on nprs_pkg; used by newton_polynomial_root_solver.
module nprs_divider
    import nprs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] num,
    input  logic signed [DATA_W-1:0] den,
    output logic                     done,
    output logic [32:0]              quot_sat
);
    // Dividend is num * 2^FRAC_BITS, held as a 64-bit magnitude.
    localparam int NW  = 64;
    localparam int CNT_W = 7;

    logic [NW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   q_reg, q_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic            neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    logic [NW-1:0]   num_mag;
    logic [NW:0]     trial;
    logic signed [NW:0] sq;

    always_comb
    begin
        num_mag = num[DATA_W-1] ? NW'(-$signed({{32{num[31]}}, num}))
                                : NW'({32'd0, num});
        num_mag = num_mag << FRAC_BITS;
    end

    // Shift-subtract step: bring in the next dividend bit, try the subtract.
    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            rem_next  = '0;
            q_next    = num_mag;
            d_next    = den[DATA_W-1] ? DATA_W'(-den) : den;
            neg_next  = num[DATA_W-1] ^ den[DATA_W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, q_reg[NW-1]} - {33'd0, d_reg};
            if (!trial[NW])
            begin
                rem_next = trial[NW-1:0];
                q_next   = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[NW-2:0], q_reg[NW-1]};
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NW-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    // Apply the sign, then saturate to 32 bits.
    always_comb
    begin
        sq = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        if (sq > 65'sd2147483647)
            quot_sat = {1'b1, 32'h7FFF_FFFF};
        else if (sq < -65'sd2147483648)
            quot_sat = {1'b1, 32'h8000_0000};
        else
            quot_sat = {1'b0, sq[31:0]};
    end

    assign done = done_reg;

endmodule

// File: hw/rtl/newton_polynomial_root_solver.sv
// Newton-Raphson polynomial root solver top level with coefficient memory.
// Depends on nprs_pkg and nprs_divider.
//
// Load words (kind 0) write one Q16.16 coefficient. A solve
// word (kind 1) runs Newton updates on the start guess. Each update reads the
// coefficient memory once per Horner step, over a[n] down to a[0] for f and
// over a[i]*i for i from n down to 1 for f' (one step for degree zero). The
// divider then produces its 64 quotient bits, and the stop test follows. A
// solve runs at most max_iterations updates (one if that is zero), then hands
// the result to the output register. One solve is in flight at a time; while
// a result word waits in the output register, further words are accepted.
module newton_polynomial_root_solver
    import nprs_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [nprs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                 cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [nprs_pkg::DEG_W-1:0]  coef_index,
    input  logic signed [31:0]          coef_value,
    input  logic signed [31:0]          start_guess,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [31:0]          root,
    output logic [1:0]                  status,
    output logic [nprs_pkg::ITER_W-1:0] iterations
);
    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FRD    = 9'b000000010,
        S_FMUL   = 9'b000000100,
        S_DRD    = 9'b000001000,
        S_DMUL   = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_DWAIT  = 9'b001000000,
        S_CHECK  = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    // Coefficient memory, one write and one registered read port.
    logic [DATA_W-1:0] mem [DEPTH];
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata, mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata <= mem[mem_raddr];
    end

    // Configuration registers.
    logic [DEG_W-1:0]  degree_reg;
    logic [31:0]       tol_reg;
    logic [ITER_W-1:0] maxit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= DEG_W'(1);
            tol_reg    <= 32'd4;
            maxit_reg  <= ITER_W'(64);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEGREE:   degree_reg <= cfg_data[DEG_W-1:0];
                REG_REL_TOL:  tol_reg    <= cfg_data;
                REG_MAX_ITER: maxit_reg  <= cfg_data[ITER_W-1:0];
                default:      ;
            endcase
        end
    end

    logic [AW-1:0] n_eff;
    logic [ITER_W-1:0] cap;
    assign n_eff = (32'(degree_reg) > MAX_DEGREE) ? AW'(MAX_DEGREE) : AW'(degree_reg);
    assign cap   = (maxit_reg == '0) ? ITER_W'(1) : maxit_reg;

    state_t state_reg, state_next;
    logic signed [31:0] x1_reg, x1_next, x0_reg, x0_next;
    logic signed [31:0] acc_reg, acc_next, f_reg, f_next;
    logic [AW-1:0]      i_reg, i_next;
    logic               first_reg, first_next;
    logic               sat_reg, sat_next;
    logic [ITER_W-1:0]  it_reg, it_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] root_reg, root_next;
    logic [1:0]         st_reg, st_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_root_reg, out_root_next;
    logic [1:0]         out_st_reg, out_st_next;
    logic [ITER_W-1:0]  out_it_reg, out_it_next;
    logic               div_start;
    logic               div_done;
    logic [32:0]        div_q;

    nprs_divider #(.FRAC_BITS(FRAC_BITS)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (f_reg),
        .den      (acc_reg),
        .done     (div_done),
        .quot_sat (div_q)
    );

    logic busy;
    assign busy     = (state_reg != S_IDLE);
    assign in_stall = busy;

    // Helper combinational values.
    logic signed [63:0] mul_sh, cmul;
    logic [32:0]        s1, s2, s3;
    logic signed [32:0] msum, dsum;
    logic [32:0]        dmag, bmag;
    logic [63:0]        rhs;
    logic               keep;

    always_comb
    begin
        state_next = state_reg;
        x1_next = x1_reg; x0_next = x0_reg; acc_next = acc_reg; f_next = f_reg;
        i_next = i_reg; first_next = first_reg; sat_next = sat_reg; it_next = it_reg;
        prod_next = prod_reg;
        root_next = root_reg; st_next = st_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_root_next = out_root_reg; out_st_next = out_st_reg; out_it_next = out_it_reg;
        mem_we = 1'b0; mem_waddr = AW'(coef_index); mem_wdata = coef_value;
        mem_raddr = i_reg;
        div_start = 1'b0;
        mul_sh = prod_reg >>> FRAC_BITS;
        cmul = $signed(mem_rdata) * $signed({1'b0, 63'(i_reg)});
        s1 = '0; s2 = '0; s3 = '0;
        msum = $signed({x1_reg[31], x1_reg}) + $signed({x0_reg[31], x0_reg});
        dsum = '0;
        dmag = '0; bmag = '0; rhs = '0; keep = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    if (!kind)
                        mem_we = (32'(coef_index) <= MAX_DEGREE);
                    else
                    begin
                        x1_next = start_guess; x0_next = start_guess;
                        it_next = '0;
                        i_next = n_eff; first_next = 1'b1; sat_next = 1'b0;
                        state_next = S_FRD;
                    end
                end
            end
            // Hand the result to the output register once it is free.
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_root_next = root_reg; out_st_next = st_reg; out_it_next = it_reg;
                    state_next = S_IDLE;
                end
            end
            // f: read a[i]; form the product of acc from the previous step and x.
            S_FRD:
            begin
                mem_raddr = i_reg;
                prod_next = 64'(acc_reg) * 64'(x1_reg);
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                if (first_reg)
                    acc_next = mem_rdata;
                else
                begin
                    s1 = sat32(mul_sh);
                    s2 = sat32(64'($signed(s1[31:0])) + 64'($signed(mem_rdata)));
                    acc_next = s2[31:0];
                    sat_next = sat_reg | s1[32] | s2[32];
                end
                first_next = 1'b0;
                if (i_reg == '0)
                begin
                    i_next = n_eff; first_next = 1'b1; state_next = S_DRD;
                    f_next = first_reg ? $signed(mem_rdata) : $signed(s2[31:0]);
                end
                else
                begin
                    i_next = i_reg - 1'b1; state_next = S_FRD;
                end
            end
            // f': Horner over a[i]*i for i from n down to 1.
            S_DRD:
            begin
                prod_next = 64'(acc_reg) * 64'(x1_reg);
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                s3 = sat32(cmul);
                if (first_reg)
                begin
                    acc_next = s3[31:0];
                    sat_next = sat_reg | s3[32];
                end
                else
                begin
                    s1 = sat32(mul_sh);
                    s2 = sat32(64'($signed(s1[31:0])) + 64'($signed(s3[31:0])));
                    acc_next = s2[31:0];
                    sat_next = sat_reg | s1[32] | s2[32] | s3[32];
                end
                if (i_reg == '0)
                    acc_next = '0;
                first_next = 1'b0;
                if (i_reg <= AW'(1))
                    state_next = S_DIV;
                else
                begin
                    i_next = i_reg - 1'b1; state_next = S_DRD;
                end
            end
            S_DIV:
            begin
                if (acc_reg == '0)
                begin
                    st_next = ST_ZERO_DER; root_next = x1_reg; state_next = S_OUT;
                end
                else
                begin
                    div_start = 1'b1; state_next = S_DWAIT;
                end
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    s1 = sat32(64'(x1_reg) - 64'($signed(div_q[31:0])));
                    x0_next = s1[31:0];
                    sat_next = sat_reg | div_q[32] | s1[32];
                    it_next = it_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end
            // Stop tests in order: saturation, convergence, cap.
            S_CHECK:
            begin
                root_next = msum[32:1];
                dsum = $signed({x1_reg[31], x1_reg}) - $signed({x0_reg[31], x0_reg});
                dmag = dsum[32] ? 33'(-dsum) : 33'(dsum);
                bmag = (x1_reg == 0) ? 33'(1) << FRAC_BITS :
                       (x1_reg[31] ? 33'(-{x1_reg[31], x1_reg}) : 33'(x1_reg));
                rhs  = 64'(tol_reg) * 64'(bmag);
                keep = dmag[32] | dmag[31] | ({dmag[31:0], 32'd0} >= rhs);
                if (sat_reg)
                begin
                    st_next = ST_SATURATED; state_next = S_OUT;
                end
                else if (!keep)
                begin
                    st_next = ST_CONVERGED; state_next = S_OUT;
                end
                else if (it_reg >= cap)
                begin
                    st_next = ST_ITER_CAP; state_next = S_OUT;
                end
                else
                begin
                    x1_next = x0_reg; i_next = n_eff; first_next = 1'b1;
                    state_next = S_FRD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            it_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            it_reg        <= it_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg <= x1_next; x0_reg <= x0_next; acc_reg <= acc_next; f_reg <= f_next;
        i_reg <= i_next; first_reg <= first_next; sat_reg <= sat_next;
        prod_reg <= prod_next;
        root_reg <= root_next; st_reg <= st_next;
        out_root_reg <= out_root_next; out_st_reg <= out_st_next; out_it_reg <= out_it_next;
    end

    assign out_valid  = out_valid_reg;
    assign root       = out_root_reg;
    assign status     = out_st_reg;
    assign iterations = out_it_reg;

endmodule
